// ===== rtl/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcc_pkg
// shared types and constants for the luhn card number classifier
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int CARD_W     = 63;
    localparam int NUM_DIGITS = 19;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int CNT_W      = 6;
    localparam int COUNT_W    = 5;
    localparam int LEAD_W     = 7;
    localparam int BRAND_W    = 2;

    localparam logic [BRAND_W-1:0] BRAND_INVALID    = 2'd0;
    localparam logic [BRAND_W-1:0] BRAND_AMEX       = 2'd1;
    localparam logic [BRAND_W-1:0] BRAND_VISA       = 2'd2;
    localparam logic [BRAND_W-1:0] BRAND_MASTERCARD = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOAD,
        ST_WALK,
        ST_DONE
    } lcc_state_t;

    typedef struct packed {
        logic conv_load;
        logic conv_shift;
        logic walk_load;
        logic walk_step;
    } lcc_ctrl_t;

    typedef struct packed {
        logic               luhn_ok;
        logic [COUNT_W-1:0] digit_count;
        logic [LEAD_W-1:0]  leading_pair;
    } lcc_walk_res_t;

endpackage

// ===== rtl/luhn_card_number_classifier_core.sv =====
// ----------------------------------------------------------------------------
// luhn_card_number_classifier_core
// luhn check, digit count, leading pair and brand of one card number
//
// channel   ports                                            handshake
// input     card_number                                      start, busy
// result    brand, luhn_ok, digit_count, leading_pair        done
//
// a transaction is taken when start is high and busy is low
// busy stays high through the bit-serial bcd conversion, the load of the digits,
// the digit walk and the step that forms the result
// done pulses for one cycle with the result, in the first cycle with busy low
// the receiver cannot stall; reset clears the sequencer and the strobe
// ----------------------------------------------------------------------------
module luhn_card_number_classifier_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lcc_pkg::CARD_W-1:0]      card_number,
    output logic                            done,
    output logic [lcc_pkg::BRAND_W-1:0]     brand,
    output logic                            luhn_ok,
    output logic [lcc_pkg::COUNT_W-1:0]     digit_count,
    output logic [lcc_pkg::LEAD_W-1:0]      leading_pair
);

    localparam logic [lcc_pkg::CNT_W-1:0] CONV_LAST = lcc_pkg::CNT_W'(lcc_pkg::CARD_W - 1);
    localparam logic [lcc_pkg::CNT_W-1:0] WALK_LAST =
        lcc_pkg::CNT_W'(lcc_pkg::NUM_DIGITS - 1);

    lcc_pkg::lcc_state_t          state_reg;
    lcc_pkg::lcc_state_t          state_next;
    logic [lcc_pkg::CNT_W-1:0]    cnt_reg;
    logic [lcc_pkg::CNT_W-1:0]    cnt_next;
    logic                         done_reg;
    logic                         done_next;
    logic [lcc_pkg::BRAND_W-1:0]  brand_reg;
    logic                         luhn_ok_reg;
    logic [lcc_pkg::COUNT_W-1:0]  count_reg;
    logic [lcc_pkg::LEAD_W-1:0]   lead_reg;
    logic [lcc_pkg::BRAND_W-1:0]  brand_calc;

    lcc_pkg::lcc_ctrl_t           ctrl;
    lcc_pkg::lcc_walk_res_t       walk_res;
    logic [lcc_pkg::BCD_W-1:0]    bcd;

    logic                         accept;

    assign accept = start && (state_reg == lcc_pkg::ST_IDLE);

    lcc_bcd_conv u_conv
    (
        .clk         (clk),
        .ctrl        (ctrl),
        .card_number (card_number),
        .bcd         (bcd)
    );

    lcc_digit_walk u_walk
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .bcd   (bcd),
        .res   (walk_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            lcc_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                    state_next = lcc_pkg::ST_CONV;
            end
            lcc_pkg::ST_CONV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CONV_LAST)
                begin
                    state_next = lcc_pkg::ST_LOAD;
                    cnt_next   = '0;
                end
            end
            lcc_pkg::ST_LOAD:
            begin
                state_next = lcc_pkg::ST_WALK;
            end
            lcc_pkg::ST_WALK:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == WALK_LAST)
                begin
                    state_next = lcc_pkg::ST_DONE;
                    cnt_next   = '0;
                end
            end
            lcc_pkg::ST_DONE:
            begin
                state_next = lcc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lcc_pkg::ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        ctrl      = '0;
        done_next = 1'b0;
        unique case (state_reg)
            lcc_pkg::ST_IDLE: ctrl.conv_load  = accept;
            lcc_pkg::ST_CONV: ctrl.conv_shift = 1'b1;
            lcc_pkg::ST_LOAD: ctrl.walk_load  = 1'b1;
            lcc_pkg::ST_WALK: ctrl.walk_step  = 1'b1;
            lcc_pkg::ST_DONE: done_next       = 1'b1;
            default:          ctrl            = '0;
        endcase
    end

    // brand rules in priority order
    always_comb
    begin
        priority if (!walk_res.luhn_ok)
            brand_calc = lcc_pkg::BRAND_INVALID;
        else if (walk_res.digit_count == 5'd15 &&
                 (walk_res.leading_pair == 7'd34 || walk_res.leading_pair == 7'd37))
            brand_calc = lcc_pkg::BRAND_AMEX;
        else if ((walk_res.digit_count == 5'd13 || walk_res.digit_count == 5'd16) &&
                 walk_res.leading_pair >= 7'd40 && walk_res.leading_pair <= 7'd49)
            brand_calc = lcc_pkg::BRAND_VISA;
        else if (walk_res.digit_count == 5'd16 &&
                 walk_res.leading_pair >= 7'd51 && walk_res.leading_pair <= 7'd55)
            brand_calc = lcc_pkg::BRAND_MASTERCARD;
        else
            brand_calc = lcc_pkg::BRAND_INVALID;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcc_pkg::ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            brand_reg   <= brand_calc;
            luhn_ok_reg <= walk_res.luhn_ok;
            count_reg   <= walk_res.digit_count;
            lead_reg    <= walk_res.leading_pair;
        end
    end

    assign busy         = (state_reg != lcc_pkg::ST_IDLE);
    assign done         = done_reg;
    assign brand        = brand_reg;
    assign luhn_ok      = luhn_ok_reg;
    assign digit_count  = count_reg;
    assign leading_pair = lead_reg;

    // result strobe only follows the final sequencer step
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == lcc_pkg::ST_DONE))
        else $error("done without finishing step");

    // busy only rises on an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    // a branded result must have passed the luhn check
    assert property (@(posedge clk) disable iff (!rst_n)
        done && (brand != lcc_pkg::BRAND_INVALID) |-> luhn_ok)
        else $error("brand given on luhn failure");

    // digit count stays within the range of a 63-bit number
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (digit_count <= 5'd19))
        else $error("digit count out of range");

    // conversion always hands over to the digit load
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lcc_pkg::ST_CONV) && (cnt_reg == CONV_LAST) |=>
        (state_reg == lcc_pkg::ST_LOAD))
        else $error("conversion did not end in load");

endmodule

// ===== rtl/lcc_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// lcc_bcd_conv
// shift-and-add-3 binary to bcd converter, one input bit per cycle
// ----------------------------------------------------------------------------
module lcc_bcd_conv
(
    input  logic                          clk,
    input  lcc_pkg::lcc_ctrl_t            ctrl,
    input  logic [lcc_pkg::CARD_W-1:0]    card_number,
    output logic [lcc_pkg::BCD_W-1:0]     bcd
);

    logic [lcc_pkg::CARD_W-1:0] bin_reg;
    logic [lcc_pkg::CARD_W-1:0] bin_next;
    logic [lcc_pkg::BCD_W-1:0]  bcd_reg;
    logic [lcc_pkg::BCD_W-1:0]  bcd_next;
    logic [lcc_pkg::BCD_W-1:0]  bcd_adj;

    // add 3 to every digit of five or more, then shift in the next bit
    always_comb
    begin
        logic [3:0] dig;
        for (int i = 0; i < lcc_pkg::NUM_DIGITS; i++)
        begin
            dig = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (ctrl.conv_load)
        begin
            bin_next = card_number;
            bcd_next = '0;
        end
        else if (ctrl.conv_shift)
        begin
            bin_next = {bin_reg[lcc_pkg::CARD_W-2:0], 1'b0};
            bcd_next = {bcd_adj[lcc_pkg::BCD_W-2:0], bin_reg[lcc_pkg::CARD_W-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd = bcd_reg;

endmodule

// ===== rtl/lcc_digit_walk.sv =====
// ----------------------------------------------------------------------------
// lcc_digit_walk
// walks bcd digits from the low end: luhn sum mod 10, digit count, lead pair
// ----------------------------------------------------------------------------
module lcc_digit_walk
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lcc_pkg::lcc_ctrl_t            ctrl,
    input  logic [lcc_pkg::BCD_W-1:0]     bcd,
    output lcc_pkg::lcc_walk_res_t        res
);

    logic [lcc_pkg::BCD_W-1:0]   dig_reg;
    logic [lcc_pkg::BCD_W-1:0]   dig_next;
    logic [lcc_pkg::COUNT_W-1:0] idx_reg;
    logic [lcc_pkg::COUNT_W-1:0] idx_next;
    logic [3:0]                  sum_reg;
    logic [3:0]                  sum_next;
    logic [lcc_pkg::COUNT_W-1:0] count_reg;
    logic [lcc_pkg::COUNT_W-1:0] count_next;
    logic [lcc_pkg::LEAD_W-1:0]  lead_reg;
    logic [lcc_pkg::LEAD_W-1:0]  lead_next;
    logic [3:0]                  prev_reg;
    logic [3:0]                  prev_next;

    logic [3:0]                  d;
    logic [3:0]                  dv;
    logic [4:0]                  sum_add;
    logic [lcc_pkg::LEAD_W-1:0]  d_ext;

    function automatic logic [3:0] luhn_double(input logic [3:0] x);
        logic [4:0] t;
        t = {x, 1'b0};
        return (t > 5'd9) ? 4'(t - 5'd9) : t[3:0];
    endfunction

    assign d       = dig_reg[3:0];
    assign dv      = idx_reg[0] ? luhn_double(d) : d;
    assign sum_add = {1'b0, sum_reg} + {1'b0, dv};
    assign d_ext   = {3'b000, d};

    always_comb
    begin
        dig_next   = dig_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        lead_next  = lead_reg;
        prev_next  = prev_reg;
        if (ctrl.walk_load)
        begin
            dig_next   = bcd;
            idx_next   = '0;
            sum_next   = '0;
            count_next = '0;
            lead_next  = '0;
            prev_next  = '0;
        end
        else if (ctrl.walk_step)
        begin
            dig_next  = {4'b0000, dig_reg[lcc_pkg::BCD_W-1:4]};
            idx_next  = idx_reg + 1'b1;
            sum_next  = (sum_add >= 5'd10) ? 4'(sum_add - 5'd10) : sum_add[3:0];
            prev_next = d;
            // a nonzero digit is the highest one seen so far
            if (d != 4'd0)
            begin
                count_next = idx_reg + 1'b1;
                if (idx_reg == '0)
                    lead_next = d_ext;
                else
                    lead_next = (d_ext << 3) + (d_ext << 1) + {3'b000, prev_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg   <= dig_next;
        sum_reg   <= sum_next;
        count_reg <= count_next;
        lead_reg  <= lead_next;
        prev_reg  <= prev_next;
    end

    assign res.luhn_ok      = (sum_reg == 4'd0);
    assign res.digit_count  = count_reg;
    assign res.leading_pair = lead_reg;

endmodule
